### src/pfx_eval_pkg.sv
// Package: character codes, error codes and sequencer state for the postfix evaluator.
package pfx_eval_pkg;

    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_STAR  = 8'h2A;
    localparam logic [7:0] C_SLASH = 8'h2F;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_NINE  = 8'h39;

    localparam logic [31:0] EMPTY_POP_VALUE = 32'hFA0A_1EFF; // -100000001

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
    localparam logic [1:0] ERR_DIVZERO   = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,    // wait for a character
        ST_RD_B,    // stack read of b issued
        ST_RD_A,    // b captured, read of a issued
        ST_CALC,    // a captured
        ST_MUL,     // run the operator, start the divider
        ST_DIV,     // divider running
        ST_PUSH,    // push the operator result
        ST_TOP_RD,  // reissue the top read after a pushed number
        ST_TOP,     // top read data available for a newline
        ST_EMIT     // drive the result word
    } t_state;

    // Divider start and finish between top level and divider.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

endpackage

### src/pfx_eval_div.sv
// Iterative 32-bit signed divider, truncating toward zero, one quotient bit a cycle.
module pfx_eval_div
    import pfx_eval_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_den, n_den;
    logic        r_neg, n_neg;
    logic        r_done, n_done;
    logic [32:0] trial;
    logic [31:0] ma, mb;

    assign ma = i_req.dividend[31] ? 32'(-i_req.dividend) : i_req.dividend;
    assign mb = i_req.divisor[31]  ? 32'(-i_req.divisor)  : i_req.divisor;
    assign trial = {r_rem, r_quo[31]} - {1'b0, r_den};

    // Restoring division step
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_neg  = r_neg;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_rem  = '0;
            n_quo  = ma;
            n_den  = mb;
            n_neg  = i_req.dividend[31] ^ i_req.divisor[31];
        end else if (r_busy) begin
            if (!trial[32]) begin
                n_rem = trial[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_quo[31]};
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? 32'(-r_quo) : r_quo;

endmodule

### src/postfix_expression_evaluator_core.sv
// Top level: postfix expression evaluator with a memory-held operand stack.
//
// One ASCII character arrives per input word on the s_axis channel (tdata[7:0]).
// Digits build a number, space or newline pushes it, + - * / pop two operands
// and push the result. A newline sends one result word on m_axis:
// tdata[31:0] is the stack top, tdata[33:32] the error code; then the stack
// and the sticky error clear.
// Flow: a digit, an ignored character or a space is handled in the idle state;
// + - * and a divide by zero step through accept, two pops through the
// registered read port, capture, operate and push; / also waits on the
// one-bit-a-cycle divider. A newline puts the result word out through the
// registered top read, which is reissued when a pending number is pushed first;
// the next character is taken the cycle after the word leaves.
// s_axis_tready is low while an item is in work or a result word waits.
// When the receiver stalls, the result word holds in the output register and
// no new character is taken until it is taken.
// Reset (i_rst_n low, synchronous) empties the stack and clears the error;
// the RAM contents need no clearing.
module postfix_expression_evaluator_core
    import pfx_eval_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [31:0] value, [33:32] error_code, rest zero
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    logic [31:0] r_mem [STACK_DEPTH];
    logic [31:0] r_rd;

    t_state      r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [31:0] r_acc, n_acc;
    logic        r_pend, n_pend;
    logic [1:0]  r_err, n_err;
    logic [7:0]  r_op, n_op;
    logic [31:0] r_b, n_b;
    logic [31:0] r_a, n_a;
    logic        r_bemp, n_bemp;
    logic        r_aemp, n_aemp;
    logic [31:0] r_res, n_res;
    logic [31:0] r_oval, n_oval;
    logic [1:0]  r_ocode, n_ocode;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata;
    t_div_req      div_req;
    t_div_rsp      div_rsp;
    logic          acc;
    logic [31:0]   acc10;

    // Operand stack RAM, registered read
    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rd <= r_mem[raddr];
    end

    pfx_eval_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign acc   = s_axis_tvalid && s_axis_tready;
    assign acc10 = 32'((r_acc << 3) + (r_acc << 1)) + {24'd0, s_axis_tdata - C_ZERO};
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_EMIT);
    assign m_axis_tdata  = {6'd0, r_ocode, r_oval};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_pend  <= 1'b0;
            r_err   <= ERR_NONE;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_pend  <= n_pend;
            r_err   <= n_err;
        end
        r_op    <= n_op;
        r_b     <= n_b;
        r_a     <= n_a;
        r_bemp  <= n_bemp;
        r_aemp  <= n_aemp;
        r_res   <= n_res;
        r_oval  <= n_oval;
        r_ocode <= n_ocode;
    end

    // Sequencer: flush pending number, pop, compute, push, emit
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_pend  = r_pend;
        n_err   = r_err;
        n_op    = r_op;
        n_b     = r_b;
        n_a     = r_a;
        n_bemp  = r_bemp;
        n_aemp  = r_aemp;
        n_res   = r_res;
        n_oval  = r_oval;
        n_ocode = r_ocode;
        we      = 1'b0;
        waddr   = r_cnt[AW-1:0];
        wdata   = r_acc;
        raddr   = AW'(r_cnt - CW'(1));
        div_req = '{start: 1'b0, dividend: r_a, divisor: r_b};
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_op = s_axis_tdata;
                    if (s_axis_tdata >= C_ZERO && s_axis_tdata <= C_NINE) begin
                        n_acc  = acc10;
                        n_pend = 1'b1;
                    end else if (s_axis_tdata == C_SPACE || s_axis_tdata == C_LF ||
                                 s_axis_tdata == C_PLUS || s_axis_tdata == C_MINUS ||
                                 s_axis_tdata == C_STAR || s_axis_tdata == C_SLASH) begin
                        // flush the pending number
                        if (r_pend) begin
                            if (r_cnt >= FULL) begin
                                if (r_err == ERR_NONE) n_err = ERR_OVERFLOW;
                            end else begin
                                we    = 1'b1;
                                n_cnt = r_cnt + CW'(1);
                            end
                        end
                        n_acc  = '0;
                        n_pend = 1'b0;
                        // a push moves the top, so its read goes out again
                        if (s_axis_tdata == C_LF) n_state = we ? ST_TOP_RD : ST_TOP;
                        else if (s_axis_tdata != C_SPACE) n_state = ST_RD_B;
                    end
                end
            end
            ST_RD_B: begin
                // read of b issued this cycle at cnt-1; empty stack pops the fill value
                n_state = ST_RD_A;
                n_bemp  = (r_cnt == '0);
                if (r_cnt != '0) n_cnt = r_cnt - CW'(1);
                else if (r_err == ERR_NONE) n_err = ERR_UNDERFLOW;
            end
            ST_RD_A: begin
                // capture b, issue read of a
                n_state = ST_CALC;
                n_b     = r_bemp ? EMPTY_POP_VALUE : r_rd;
                n_aemp  = (r_cnt == '0);
                if (r_cnt != '0) n_cnt = r_cnt - CW'(1);
                else if (r_err == ERR_NONE) n_err = ERR_UNDERFLOW;
            end
            ST_CALC: begin
                n_a = r_aemp ? EMPTY_POP_VALUE : r_rd;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_res = r_a;
                n_state = ST_PUSH;
                case (r_op)
                    C_PLUS:  n_res = r_a + r_b;
                    C_MINUS: n_res = r_a - r_b;
                    C_STAR:  n_res = 32'(r_a * r_b);
                    default: begin
                        if (r_b == '0) begin
                            if (r_err == ERR_NONE) n_err = ERR_DIVZERO;
                            n_res = '0;
                        end else begin
                            div_req.start = 1'b1;
                            n_state = ST_DIV;
                        end
                    end
                endcase
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_res   = div_rsp.quotient;
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (r_cnt >= FULL) begin
                    if (r_err == ERR_NONE) n_err = ERR_OVERFLOW;
                end else begin
                    we    = 1'b1;
                    wdata = r_res;
                    n_cnt = r_cnt + CW'(1);
                end
                n_state = ST_IDLE;
            end
            ST_TOP_RD: begin
                // read of the new top issued this cycle
                n_state = ST_TOP;
            end
            ST_TOP: begin
                // top read data is on r_rd
                n_state = ST_EMIT;
                if (r_cnt == '0) begin
                    n_oval  = EMPTY_POP_VALUE;
                    n_ocode = (r_err != ERR_NONE) ? r_err : ERR_UNDERFLOW;
                end else begin
                    n_oval  = r_rd;
                    n_ocode = r_err;
                end
                n_cnt = '0;
                n_err = ERR_NONE;
            end
            ST_EMIT: begin
                if (m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

### src/postfix_expression_evaluator_core_chk.sv
// Checker on the evaluator's ports, bound to the top level.
module pfx_eval_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input open while result waits");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word dropped or changed");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:34] == 6'd0) else $error("pad bits set");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid) else $error("result after reset");
endmodule

bind postfix_expression_evaluator_core pfx_eval_chk u_chk (.*);

### dv/tb.sv
// Testbench for the postfix expression evaluator: directed and random expressions vs a predictor.
module tb
    import pfx_eval_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int IDLE_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] ch
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // [31:0] value, [33:32] error_code

    typedef struct packed {
        logic [1:0]  code;
        logic [31:0] value;
    } t_answer;

    // predictor state
    logic [31:0] calc_stack [DEPTH];
    int          calc_depth;
    logic [31:0] calc_accum;
    logic        calc_pending;
    logic [1:0]  calc_err;
    t_answer     answer_q [$];

    int  fail_cnt;
    bit  rx_fast;       // no receiver stalls
    bit  tx_fast;       // no sender gaps
    bit  rx_hold;       // long receiver hold-off
    int  idle_cnt;

    postfix_expression_evaluator_core #(.STACK_DEPTH(DEPTH)) dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // --- predictor ---
    function automatic void raise_err(logic [1:0] c);
        if (calc_err == ERR_NONE) calc_err = c;
    endfunction

    function automatic void push_calc(logic [31:0] v);
        if (calc_depth >= DEPTH) raise_err(ERR_OVERFLOW);
        else begin
            calc_stack[calc_depth] = v;
            calc_depth++;
        end
    endfunction

    function automatic logic [31:0] pop_calc();
        if (calc_depth == 0) begin
            raise_err(ERR_UNDERFLOW);
            return EMPTY_POP_VALUE;
        end
        calc_depth--;
        return calc_stack[calc_depth];
    endfunction

    function automatic void flush_num();
        if (calc_pending) push_calc(calc_accum);
        calc_accum = '0;
        calc_pending = 1'b0;
    endfunction

    function automatic void eval_char(logic [7:0] c);
        logic [31:0] a, b, r;
        logic signed [31:0] sa, sb;
        t_answer ans;
        if (c >= C_ZERO && c <= C_NINE) begin
            calc_accum = calc_accum * 32'd10 + 32'(c - C_ZERO);
            calc_pending = 1'b1;
        end else if (c == C_SPACE) begin
            flush_num();
        end else if (c == C_PLUS || c == C_MINUS || c == C_STAR || c == C_SLASH) begin
            flush_num();
            b = pop_calc();
            a = pop_calc();
            sa = a;
            sb = b;
            case (c)
                C_PLUS:  r = a + b;
                C_MINUS: r = a - b;
                C_STAR:  r = a * b;
                default: begin
                    if (b == 0) begin
                        raise_err(ERR_DIVZERO);
                        r = '0;
                    end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) r = a;
                    else r = sa / sb;
                end
            endcase
            push_calc(r);
        end else if (c == C_LF) begin
            flush_num();
            if (calc_depth == 0) begin
                ans.value = EMPTY_POP_VALUE;
                ans.code = (calc_err != ERR_NONE) ? calc_err : ERR_UNDERFLOW;
            end else begin
                ans.value = calc_stack[calc_depth - 1];
                ans.code = calc_err;
            end
            answer_q.push_back(ans);
            calc_depth = 0;
            calc_err = ERR_NONE;
        end
    endfunction

    // --- driver ---
    task automatic send_char(logic [7:0] c);
        int gap;
        if (!tx_fast && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        eval_char(c);
    endtask

    task automatic send_str(string s);
        foreach (s[i]) send_char(s[i]);
    endtask

    task automatic drop_valid();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        drop_valid();
        while (answer_q.size() != 0) @(posedge i_clk);
    endtask

    // --- result checker and receiver ---
    always @(posedge i_clk) begin
        t_answer exp_a;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected result word %h", $realtime, m_axis_tdata);
                fail_cnt++;
            end else begin
                exp_a = answer_q.pop_front();
                if (m_axis_tdata[31:0] !== exp_a.value) begin
                    $display("%0t: value exp %h got %h", $realtime, exp_a.value,
                             m_axis_tdata[31:0]);
                    fail_cnt++;
                end
                if (m_axis_tdata[33:32] !== exp_a.code) begin
                    $display("%0t: error_code exp %0d got %0d", $realtime, exp_a.code,
                             m_axis_tdata[33:32]);
                    fail_cnt++;
                end
                if (m_axis_tdata[39:34] !== '0) begin
                    $display("%0t: pad bits exp 0 got %h", $realtime, m_axis_tdata[39:34]);
                    fail_cnt++;
                end
            end
        end
    end

    int rx_stall;
    always @(posedge i_clk) begin
        if (rx_hold) m_axis_tready <= 1'b0;
        else if (rx_fast) m_axis_tready <= 1'b1;
        else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            rx_stall <= $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end else m_axis_tready <= 1'b1;
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt > IDLE_LIMIT) begin
            $display("** postfix_expression_evaluator_core: FAILED **");
            $finish;
        end
    end

    // --- stimulus helpers ---
    function automatic string rand_num();
        string s;
        int n;
        s = "";
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
        repeat (n) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        return s;
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 3))
            0: return C_PLUS;
            1: return C_MINUS;
            2: return C_STAR;
            default: return C_SLASH;
        endcase
    endfunction

    // well-formed expression, sometimes broken, with random content
    task automatic send_rand_expr(output int n_chars);
        int leaves, live, k;
        string num;
        n_chars = 0;
        leaves = $urandom_range(1, 6);
        live = 0;
        for (k = 0; k < leaves; k++) begin
            num = rand_num();
            send_str(num);
            send_char(C_SPACE);
            live++;
            n_chars += num.len() + 1;
            while (live > 1 && $urandom_range(0, 1)) begin
                send_char(rand_op());
                live--;
                n_chars++;
            end
        end
        while (live > 1) begin
            send_char(rand_op());
            live--;
            n_chars++;
        end
        // noise or breakage
        if ($urandom_range(0, 4) == 0) begin
            send_char(rand_op());
            n_chars++;
        end
        if ($urandom_range(0, 5) == 0) begin
            send_char(8'($urandom_range(0, 255)));
            n_chars++;
        end
        if ($urandom_range(0, 6) == 0) begin
            send_str("0/");
            n_chars += 2;
        end
        send_char(C_LF);
        n_chars++;
    endtask

    // --- tests ---
    task automatic test_directed();
        send_str("3 4 +\n");
        send_str("10 3 -\n");
        send_str("7 6*\n");
        send_str("4294967295 1+\n");            // max accumulator, wrap add
        send_str("99999999999 \n");             // long number wraps
        send_str("0 7 - 2 /\n");                // truncation toward zero
        send_str("2147483648 0 1 - /\n");        // min / -1
        send_str("5 0 /\n");                    // divide by zero
        send_str("+\n");                        // underflow
        send_str("\n");                         // empty stack
        send_str("1 0/ +\n");                   // first error sticks
        send_char(8'hFF);
        send_str("1a2\r3 \n");                  // ignored chars inside a number
    endtask

    task automatic test_overflow();
        repeat (DEPTH + 2) send_str("1 ");
        send_str("+ /\n");
        wait_drained();
    endtask

    task automatic test_all_bytes();
        int i;
        for (i = 0; i < 256; i++) send_char(8'(i));
        send_char(C_LF);
        wait_drained();
    endtask

    task automatic test_backpressure();
        int n;
        rx_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            repeat (6) send_rand_expr(n);
        join
        wait_drained();
    endtask

    task automatic test_random(int target);
        int sent, n;
        sent = 0;
        while (sent < target) begin
            if (sent > target * 4 / 5) begin
                tx_fast = 1'b1;
                rx_fast = 1'b1;
            end
            send_rand_expr(n);
            sent += n;
            if ($urandom_range(0, 40) == 0) wait_drained();
        end
    endtask

    initial begin
        fail_cnt = 0;
        calc_depth = 0;
        calc_accum = '0;
        calc_pending = 1'b0;
        calc_err = ERR_NONE;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_drained();
        test_overflow();
        test_all_bytes();
        test_backpressure();
        test_random(940);
        wait_drained();
        repeat (60) @(posedge i_clk);
        if (fail_cnt == 0 && answer_q.size() == 0)
            $display("** postfix_expression_evaluator_core: PASSED **");
        else
            $display("** postfix_expression_evaluator_core: FAILED **");
        $finish;
    end
endmodule
